>>> src/flt_pkg.sv
// Package for the stack-language token lexer.
// Holds scan modes, token kinds, character constants, class functions and queue records.
// No dependencies.
package flt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_MINUS,
        MODE_IDENT,
        MODE_STRING,
        MODE_COMMENT,
        MODE_DEAD
    } t_mode;

    typedef enum logic [3:0] {
        KIND_NUMBER   = 4'd0,
        KIND_IDENT    = 4'd1,
        KIND_STRING   = 4'd2,
        KIND_LBRACKET = 4'd3,
        KIND_RBRACKET = 4'd4,
        KIND_COMMENT  = 4'd5,
        KIND_END      = 4'd6,
        KIND_UNTERM   = 4'd7,
        KIND_BAD      = 4'd8
    } t_kind;

    localparam int unsigned OUT_W       = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;

    typedef struct packed {
        t_kind              kind;
        logic [OUT_W-1:0]   start;
        logic [OUT_W-1:0]   len;
    } t_tok;

    // one queue entry: results caused by one input byte
    typedef struct packed {
        logic two;
        t_tok t0;
        t_tok t1;
    } t_entry;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'd32) || (c inside {[8'd9:8'd13]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // letters and + - * / % > < =
    function automatic logic is_word(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) ||
               (c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h3E, 8'h3C, 8'h3D});
    endfunction

endpackage

>>> src/flt_front.sv
// Scanner front end: accepts bytes, tracks the scan mode and offsets,
// and pushes the zero to two tokens each byte closes. Depends on flt_pkg.
module flt_front
    import flt_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_take,
    input  logic [7:0] i_text_byte,
    input  logic   i_end_of_text,
    output logic   o_push,
    output t_entry o_entry
);

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;

    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] span_pos;
    logic [OFFSET_BITS-1:0] span_inc;

    // token-start logic for a byte seen between tokens
    t_mode                  b_mode;
    logic [OFFSET_BITS-1:0] b_start;
    logic                   b_emit;
    t_tok                   b_tok;

    // token closed by this byte, and the result of starting anew
    logic                   c_emit;
    t_tok                   c_tok;
    logic                   s_emit;
    t_tok                   s_tok;

    assign pos_inc  = r_pos + 1'b1;
    assign span_pos = r_pos - r_start;
    assign span_inc = pos_inc - r_start;

    always_comb begin
        b_mode   = MODE_IDLE;
        b_start  = r_start;
        b_emit   = 1'b0;
        b_tok    = '{kind: KIND_BAD, start: OUT_W'(r_pos), len: OUT_W'(1)};
        if (is_blank(i_text_byte)) begin
            b_mode = MODE_IDLE;
        end else if (is_digit(i_text_byte)) begin
            b_mode  = MODE_NUMBER;
            b_start = r_pos;
        end else if (i_text_byte == CH_MINUS) begin
            b_mode  = MODE_MINUS;
            b_start = r_pos;
        end else if (is_word(i_text_byte)) begin
            b_mode  = MODE_IDENT;
            b_start = r_pos;
        end else if (i_text_byte == CH_QUOTE) begin
            b_mode  = MODE_STRING;
            b_start = pos_inc;
        end else if (i_text_byte == CH_LBRACKET) begin
            b_emit     = 1'b1;
            b_tok.kind = KIND_LBRACKET;
        end else if (i_text_byte == CH_RBRACKET) begin
            b_emit     = 1'b1;
            b_tok.kind = KIND_RBRACKET;
        end else if (i_text_byte == CH_HASH) begin
            b_mode  = MODE_COMMENT;
            b_start = pos_inc;
        end else begin
            b_emit = 1'b1;
            b_mode = MODE_DEAD;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_pos   = pos_inc;
        c_emit  = 1'b0;
        c_tok   = '{kind: KIND_NUMBER, start: OUT_W'(r_start), len: OUT_W'(span_pos)};
        s_emit  = 1'b0;
        s_tok   = b_tok;
        if (i_end_of_text) begin
            n_mode  = MODE_IDLE;
            n_start = '0;
            n_pos   = '0;
            s_emit  = 1'b1;
            s_tok   = '{kind: KIND_END, start: OUT_W'(r_pos), len: '0};
            case (r_mode)
                MODE_NUMBER: begin
                    c_emit = 1'b1;
                end
                MODE_MINUS, MODE_IDENT: begin
                    c_emit     = 1'b1;
                    c_tok.kind = KIND_IDENT;
                end
                MODE_STRING: begin
                    c_emit     = 1'b1;
                    c_tok.kind = KIND_UNTERM;
                end
                MODE_COMMENT: begin
                    c_emit     = 1'b1;
                    c_tok.kind = KIND_COMMENT;
                end
                default: begin
                    c_emit = 1'b0;
                end
            endcase
        end else begin
            case (r_mode)
                MODE_NUMBER: begin
                    if (!is_digit(i_text_byte)) begin
                        c_emit  = 1'b1;
                        s_emit  = b_emit;
                        n_mode  = b_mode;
                        n_start = b_start;
                    end
                end
                MODE_MINUS: begin
                    if (is_digit(i_text_byte)) begin
                        n_mode = MODE_NUMBER;
                    end else if (is_word(i_text_byte)) begin
                        n_mode = MODE_IDENT;
                    end else begin
                        c_emit     = 1'b1;
                        c_tok.kind = KIND_IDENT;
                        s_emit     = b_emit;
                        n_mode     = b_mode;
                        n_start    = b_start;
                    end
                end
                MODE_IDENT: begin
                    if (!is_word(i_text_byte)) begin
                        c_emit     = 1'b1;
                        c_tok.kind = KIND_IDENT;
                        s_emit     = b_emit;
                        n_mode     = b_mode;
                        n_start    = b_start;
                    end
                end
                MODE_STRING: begin
                    if (i_text_byte == CH_QUOTE) begin
                        c_emit     = 1'b1;
                        c_tok.kind = KIND_STRING;
                        n_mode     = MODE_IDLE;
                    end
                end
                MODE_COMMENT: begin
                    if (i_text_byte == CH_NEWLINE) begin
                        c_emit     = 1'b1;
                        c_tok.kind = KIND_COMMENT;
                        c_tok.len  = OUT_W'(span_inc);
                        n_mode     = MODE_IDLE;
                    end
                end
                MODE_DEAD: begin
                    n_mode = MODE_DEAD;
                end
                default: begin
                    s_emit  = b_emit;
                    n_mode  = b_mode;
                    n_start = b_start;
                end
            endcase
        end
    end

    always_comb begin
        o_push        = i_take && (c_emit || s_emit);
        o_entry.two   = c_emit && s_emit;
        o_entry.t0    = c_emit ? c_tok : s_tok;
        o_entry.t1    = s_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_pos   <= '0;
        end else if (i_take) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_pos   <= n_pos;
        end
    end

endmodule

>>> src/flt_queue.sv
// Short register queue of token entries between scanner and output stage.
// Depends on flt_pkg.
module flt_queue
    import flt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count, n_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

>>> src/flt_back.sv
// Output stage: takes queue entries and hands out their tokens one per transfer.
// Depends on flt_pkg.
module flt_back
    import flt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_entry           i_head,
    output logic             o_pop,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [3:0]       o_token_kind,
    output logic [OUT_W-1:0] o_start_offset,
    output logic [OUT_W-1:0] o_token_length,
    output logic             o_last_of_run
);

    t_entry r_ent;
    logic   r_valid;
    logic   r_idx;
    logic   done;
    t_tok   cur;

    assign done  = r_idx || !r_ent.two;
    assign o_pop = !i_empty && (!r_valid || (i_ready && done));

    assign cur            = r_idx ? r_ent.t1 : r_ent.t0;
    assign o_valid        = r_valid;
    assign o_token_kind   = cur.kind;
    assign o_start_offset = cur.start;
    assign o_token_length = cur.len;
    assign o_last_of_run  = done;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_idx   <= 1'b0;
        end else if (r_valid && i_ready) begin
            if (done) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= 1'b1;
            end
        end
    end

endmodule

>>> src/forth_token_lexer.sv
// Streaming lexer for a small stack language: takes one text byte (or an end mark) per
// transfer and emits (kind, start offset, length) tokens. The scanner accepts a byte every
// cycle while its four-entry token queue has room; tokens leave at one per cycle while the
// consumer is ready, so a byte that closes two tokens costs two output transfers,
// absorbed by the queue. A closed token passes through the queue and the output register
// before it appears. Offsets count modulo 2^OFFSET_BITS and are reported in 16 bits.
// Top level; depends on flt_pkg, flt_front, flt_queue, flt_back.
module forth_token_lexer
    import flt_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_token_kind,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);

    logic   take;
    logic   push;
    t_entry entry;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry head;

    assign o_ready = !full;
    assign take    = i_valid && o_ready;

    flt_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_entry       (entry)
    );

    flt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    flt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_head         (head),
        .o_pop          (pop),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

endmodule
